// ===== sv/gcrd_pkg.sv =====
package gcrd_pkg;

    // Fixed-point constants (radian angles have 30 fraction bits; UDEG_ angles are microdegrees)
    localparam int CW     = 36;   // CORDIC x, y, z width
    localparam int MW     = 33;   // multiplier operand width
    localparam int PW     = 2 * MW;
    localparam int STEP_W = 6;    // sequence counter width
    localparam int DIV_STEPS = 6; // reciprocal multiply, quotient, back-multiply, remainder, two corrections
    localparam int SQ_STEPS  = 31;

    localparam logic signed [MW-1:0] PI_Q30   = 33'sd3373259426;
    localparam logic signed [CW-1:0] GAIN_INV = 36'sd652032874;
    localparam logic signed [30:0]   UDEG_180 = 31'sd180000000;
    localparam logic signed [30:0]   UDEG_360 = 31'sd360000000;
    localparam logic signed [30:0]   UDEG_90  = 31'sd90000000;
    localparam logic [27:0]          DIV_D    = 28'd180000000;
    // floor(2^59 / 180e6)
    localparam logic [31:0]          DIV_RECIP = 32'd3202559735;
    localparam logic [23:0]          RADIUS_RST = 24'd6378388;

    // Datapath operation codes
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_ANGLE   = 5'd2;
    localparam logic [4:0] OP_REDUCE  = 5'd3;
    localparam logic [4:0] OP_FOLD    = 5'd4;
    localparam logic [4:0] OP_MULZ    = 5'd5;
    localparam logic [4:0] OP_DIVINIT = 5'd6;
    localparam logic [4:0] OP_DIV     = 5'd7;
    localparam logic [4:0] OP_ZSIGN   = 5'd8;
    localparam logic [4:0] OP_ROT     = 5'd9;
    localparam logic [4:0] OP_STORE   = 5'd10;
    localparam logic [4:0] OP_MSS     = 5'd11;
    localparam logic [4:0] OP_MCC     = 5'd12;
    localparam logic [4:0] OP_T2      = 5'd13;
    localparam logic [4:0] OP_MTC     = 5'd14;
    localparam logic [4:0] OP_ARG     = 5'd15;
    localparam logic [4:0] OP_SQMUL   = 5'd16;
    localparam logic [4:0] OP_SQINIT  = 5'd17;
    localparam logic [4:0] OP_SQ      = 5'd18;
    localparam logic [4:0] OP_VECINIT = 5'd19;
    localparam logic [4:0] OP_VEC     = 5'd20;
    localparam logic [4:0] OP_THETA   = 5'd21;
    localparam logic [4:0] OP_MULR    = 5'd22;
    localparam logic [4:0] OP_ACC     = 5'd23;
    localparam logic [4:0] OP_FINISH  = 5'd24;

    typedef struct packed {
        logic [4:0]        op;
        logic [STEP_W-1:0] step;
        logic [1:0]        slot;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic last;
        logic reduce_ok;
        logic out_block;
    } t_stat;

    // atan(2^-k) in Q30
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] k);
        logic signed [CW-1:0] v;
        unique case (k)
            5'd0:  v = 36'sh03243F6A8;
            5'd1:  v = 36'sh01DAC6705;
            5'd2:  v = 36'sh00FADBAFC;
            5'd3:  v = 36'sh007F56EA6;
            5'd4:  v = 36'sh003FEAB76;
            5'd5:  v = 36'sh001FFD55B;
            5'd6:  v = 36'sh000FFFAAA;
            5'd7:  v = 36'sh0007FFF55;
            5'd8:  v = 36'sh0003FFFEA;
            5'd9:  v = 36'sh0001FFFFD;
            5'd10: v = 36'sh0000FFFFF;
            5'd11: v = 36'sh00007FFFF;
            5'd12: v = 36'sh00003FFFF;
            5'd13: v = 36'sh00001FFFF;
            5'd14: v = 36'sh00000FFFF;
            5'd15: v = 36'sh000007FFF;
            5'd16: v = 36'sh000003FFF;
            5'd17: v = 36'sh000001FFF;
            5'd18: v = 36'sh000000FFF;
            5'd19: v = 36'sh0000007FF;
            5'd20: v = 36'sh0000003FF;
            5'd21: v = 36'sh0000001FF;
            5'd22: v = 36'sh0000000FF;
            5'd23: v = 36'sh00000007F;
            5'd24: v = 36'sh00000003F;
            5'd25: v = 36'sh00000001F;
            5'd26: v = 36'sh00000000F;
            5'd27: v = 36'sh000000008;
            5'd28: v = 36'sh000000004;
            5'd29: v = 36'sh000000002;
            5'd30: v = 36'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/gcrd_if.sv =====
// Waypoint channel
interface gcrd_pt_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] latitude_udeg;
    logic signed [28:0] longitude_udeg;
    logic               last_point;

    modport source (output valid, latitude_udeg, longitude_udeg, last_point, input ready);
    modport sink   (input valid, latitude_udeg, longitude_udeg, last_point, output ready);
endinterface

// Route total channel
interface gcrd_res_if #(parameter int TOTAL_W = 40);
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_distance_m;
    logic               saturated;

    modport source (output valid, total_distance_m, saturated, input ready);
    modport sink   (input valid, total_distance_m, saturated, output ready);
endinterface

// ===== sv/gcrd_ctrl.sv =====
module gcrd_ctrl #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  gcrd_pkg::t_stat i_stat,
    output gcrd_pkg::t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ANGLE   = 5'd1;
    localparam logic [4:0] S_REDUCE  = 5'd2;
    localparam logic [4:0] S_FOLD    = 5'd3;
    localparam logic [4:0] S_MULZ    = 5'd4;
    localparam logic [4:0] S_DIVINIT = 5'd5;
    localparam logic [4:0] S_DIV     = 5'd6;
    localparam logic [4:0] S_ZSIGN   = 5'd7;
    localparam logic [4:0] S_ROT     = 5'd8;
    localparam logic [4:0] S_STORE   = 5'd9;
    localparam logic [4:0] S_MSS     = 5'd10;
    localparam logic [4:0] S_MCC     = 5'd11;
    localparam logic [4:0] S_T2      = 5'd12;
    localparam logic [4:0] S_MTC     = 5'd13;
    localparam logic [4:0] S_ARG     = 5'd14;
    localparam logic [4:0] S_SQMUL   = 5'd15;
    localparam logic [4:0] S_SQINIT  = 5'd16;
    localparam logic [4:0] S_SQ      = 5'd17;
    localparam logic [4:0] S_VECINIT = 5'd18;
    localparam logic [4:0] S_VEC     = 5'd19;
    localparam logic [4:0] S_THETA   = 5'd20;
    localparam logic [4:0] S_MULR    = 5'd21;
    localparam logic [4:0] S_ACC     = 5'd22;
    localparam logic [4:0] S_FINISH  = 5'd23;

    localparam logic [gcrd_pkg::STEP_W-1:0] DIV_LAST  = gcrd_pkg::STEP_W'(gcrd_pkg::DIV_STEPS - 1);
    localparam logic [gcrd_pkg::STEP_W-1:0] SQ_LAST   = gcrd_pkg::STEP_W'(gcrd_pkg::SQ_STEPS - 1);
    localparam logic [gcrd_pkg::STEP_W-1:0] CORD_LAST = gcrd_pkg::STEP_W'(CORDIC_STEPS - 1);

    logic [4:0]                  r_state, n_state;
    logic [gcrd_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic [1:0]                  r_slot, n_slot;
    logic                        in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = o_in_ready && i_in_valid;

    // Command to the datapath follows the state
    always_comb begin
        o_cmd.step = r_cnt;
        o_cmd.slot = r_slot;
        unique case (r_state)
            S_IDLE:    o_cmd.op = in_fire ? gcrd_pkg::OP_LOAD : gcrd_pkg::OP_NONE;
            S_ANGLE:   o_cmd.op = gcrd_pkg::OP_ANGLE;
            S_REDUCE:  o_cmd.op = gcrd_pkg::OP_REDUCE;
            S_FOLD:    o_cmd.op = gcrd_pkg::OP_FOLD;
            S_MULZ:    o_cmd.op = gcrd_pkg::OP_MULZ;
            S_DIVINIT: o_cmd.op = gcrd_pkg::OP_DIVINIT;
            S_DIV:     o_cmd.op = gcrd_pkg::OP_DIV;
            S_ZSIGN:   o_cmd.op = gcrd_pkg::OP_ZSIGN;
            S_ROT:     o_cmd.op = gcrd_pkg::OP_ROT;
            S_STORE:   o_cmd.op = gcrd_pkg::OP_STORE;
            S_MSS:     o_cmd.op = gcrd_pkg::OP_MSS;
            S_MCC:     o_cmd.op = gcrd_pkg::OP_MCC;
            S_T2:      o_cmd.op = gcrd_pkg::OP_T2;
            S_MTC:     o_cmd.op = gcrd_pkg::OP_MTC;
            S_ARG:     o_cmd.op = gcrd_pkg::OP_ARG;
            S_SQMUL:   o_cmd.op = gcrd_pkg::OP_SQMUL;
            S_SQINIT:  o_cmd.op = gcrd_pkg::OP_SQINIT;
            S_SQ:      o_cmd.op = gcrd_pkg::OP_SQ;
            S_VECINIT: o_cmd.op = gcrd_pkg::OP_VECINIT;
            S_VEC:     o_cmd.op = gcrd_pkg::OP_VEC;
            S_THETA:   o_cmd.op = gcrd_pkg::OP_THETA;
            S_MULR:    o_cmd.op = gcrd_pkg::OP_MULR;
            S_ACC:     o_cmd.op = gcrd_pkg::OP_ACC;
            S_FINISH:  o_cmd.op = (i_stat.last && i_stat.out_block) ?
                                  gcrd_pkg::OP_NONE : gcrd_pkg::OP_FINISH;
            default:   o_cmd.op = gcrd_pkg::OP_NONE;
        endcase
    end

    // Sequencing
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_slot  = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_slot  = 2'd0;
                    n_state = i_stat.have_prev ? S_ANGLE : S_FINISH;
                end
            end
            S_ANGLE:   n_state = S_REDUCE;
            S_REDUCE: begin
                if (i_stat.reduce_ok) n_state = S_FOLD;
            end
            S_FOLD:    n_state = S_MULZ;
            S_MULZ:    n_state = S_DIVINIT;
            S_DIVINIT: n_state = S_DIV;
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_ZSIGN;
                end
            end
            S_ZSIGN:   n_state = S_ROT;
            S_ROT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORD_LAST) begin
                    n_cnt   = '0;
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_slot  = r_slot + 1'b1;
                n_state = (r_slot == 2'd2) ? S_MSS : S_ANGLE;
            end
            S_MSS:     n_state = S_MCC;
            S_MCC:     n_state = S_T2;
            S_T2:      n_state = S_MTC;
            S_MTC:     n_state = S_ARG;
            S_ARG:     n_state = S_SQMUL;
            S_SQMUL:   n_state = S_SQINIT;
            S_SQINIT:  n_state = S_SQ;
            S_SQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = S_VECINIT;
                end
            end
            S_VECINIT: n_state = S_VEC;
            S_VEC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORD_LAST) begin
                    n_cnt   = '0;
                    n_state = S_THETA;
                end
            end
            S_THETA:   n_state = S_MULR;
            S_MULR:    n_state = S_ACC;
            S_ACC:     n_state = S_FINISH;
            S_FINISH: begin
                if (!(i_stat.last && i_stat.out_block)) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_slot  <= n_slot;
        end
    end

endmodule

// ===== sv/gcrd_dp.sv =====
module gcrd_dp #(
    parameter int TOTAL_WIDTH = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gcrd_pkg::t_cmd         i_cmd,
    output gcrd_pkg::t_stat        o_stat,
    input  logic                   i_cfg_we,
    input  logic [23:0]            i_cfg_data,
    input  logic signed [27:0]     i_lat,
    input  logic signed [28:0]     i_lon,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [TOTAL_WIDTH-1:0] o_total,
    output logic                   o_saturated
);

    localparam int CW = gcrd_pkg::CW;
    localparam int MW = gcrd_pkg::MW;
    localparam int PW = gcrd_pkg::PW;
    localparam logic [TOTAL_WIDTH:0] MAXV = {1'b0, {TOTAL_WIDTH{1'b1}}};

    // Divide sequence steps
    localparam logic [gcrd_pkg::STEP_W-1:0] DS_RECIP = gcrd_pkg::STEP_W'(0);
    localparam logic [gcrd_pkg::STEP_W-1:0] DS_QEST  = gcrd_pkg::STEP_W'(1);
    localparam logic [gcrd_pkg::STEP_W-1:0] DS_BACK  = gcrd_pkg::STEP_W'(2);
    localparam logic [gcrd_pkg::STEP_W-1:0] DS_REM   = gcrd_pkg::STEP_W'(3);

    // Route state and config
    logic [23:0]            r_radius;
    logic signed [27:0]     r_prev_lat, r_lat;
    logic signed [28:0]     r_prev_lon, r_lon;
    logic                   r_last, r_have_prev;
    logic [TOTAL_WIDTH-1:0] r_total;
    logic                   r_ovf;
    logic                   r_ovalid;
    logic [TOTAL_WIDTH-1:0] r_otot;
    logic                   r_osat;

    // Working registers
    logic signed [30:0]     r_u;
    logic                   r_flip, r_zneg;
    logic signed [PW-1:0]   r_prod;
    logic [58:0]            r_mag;
    logic [29:0]            r_rem;
    logic [30:0]            r_dv;
    logic signed [CW-1:0]   r_x, r_y, r_z;
    logic signed [MW-1:0]   r_s [3];
    logic signed [MW-1:0]   r_c [3];
    logic signed [CW-1:0]   r_t1, r_t2;
    logic                   r_aneg;
    logic [30:0]            r_ax;
    logic [60:0]            r_n;
    logic [61:0]            r_r;
    logic [60:0]            r_bit;
    logic signed [MW-1:0]   r_theta;

    logic signed [MW-1:0]   ma, mb;
    logic [4:0]             k;
    logic signed [CW-1:0]   dx, dy, at, t3;
    logic signed [CW:0]     arg;
    logic signed [29:0]     dlon;
    logic [58:0]            mag;
    logic [61:0]            trial;
    logic signed [CW-1:0]   th;
    logic [PW-1:0]          legsum;
    logic [27:0]            leg;
    logic [TOTAL_WIDTH:0]   sum;
    logic signed [CW-1:0]   negx;

    assign k    = i_cmd.step[4:0];
    assign dx   = r_y >>> k;
    assign dy   = r_x >>> k;
    assign at   = gcrd_pkg::atan_q30(k);
    assign dlon = 30'(r_lon) - 30'(r_prev_lon);
    assign mag  = r_prod[PW-1] ? 59'(-r_prod) : 59'(r_prod);
    assign t3   = CW'(r_prod >>> 30);
    assign arg  = (CW+1)'(r_t1) + (CW+1)'(t3);
    assign trial = r_r + {1'b0, r_bit};
    assign th   = r_aneg ? (CW'(gcrd_pkg::PI_Q30) - r_z) : r_z;
    assign legsum = r_prod + (PW'(1) << 29);
    assign leg  = legsum[57:30];
    assign sum  = {1'b0, r_total} + (TOTAL_WIDTH+1)'(leg);
    assign negx = -r_x;

    // Shared multiplier operands
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (i_cmd.op)
            gcrd_pkg::OP_MULZ: begin
                ma = MW'(r_u);
                mb = gcrd_pkg::PI_Q30;
            end
            // quotient estimate, then its product with the divisor
            gcrd_pkg::OP_DIV: begin
                if (i_cmd.step == DS_RECIP) begin
                    ma = MW'({1'b0, r_mag[58:27]});
                    mb = MW'({1'b0, gcrd_pkg::DIV_RECIP});
                end else if (i_cmd.step == DS_BACK) begin
                    ma = MW'({1'b0, r_dv});
                    mb = MW'({1'b0, gcrd_pkg::DIV_D});
                end
            end
            gcrd_pkg::OP_MSS: begin
                ma = r_s[0];
                mb = r_s[1];
            end
            gcrd_pkg::OP_MCC: begin
                ma = r_c[0];
                mb = r_c[1];
            end
            gcrd_pkg::OP_MTC: begin
                ma = MW'(r_t2);
                mb = r_c[2];
            end
            gcrd_pkg::OP_SQMUL: begin
                ma = MW'({1'b0, r_ax});
                mb = MW'({1'b0, r_ax});
            end
            gcrd_pkg::OP_MULR: begin
                ma = MW'({1'b0, r_radius});
                mb = r_theta;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Working datapath
    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        unique case (i_cmd.op)
            gcrd_pkg::OP_LOAD: begin
                r_lat  <= i_lat;
                r_lon  <= i_lon;
                r_last <= i_last;
            end
            gcrd_pkg::OP_ANGLE: begin
                r_flip <= 1'b0;
                unique case (i_cmd.slot)
                    2'd0:    r_u <= 31'(r_prev_lat);
                    2'd1:    r_u <= 31'(r_lat);
                    default: r_u <= 31'(dlon);
                endcase
            end
            gcrd_pkg::OP_REDUCE: begin
                if (r_u > gcrd_pkg::UDEG_180)
                    r_u <= r_u - gcrd_pkg::UDEG_360;
                else if (r_u <= -gcrd_pkg::UDEG_180)
                    r_u <= r_u + gcrd_pkg::UDEG_360;
            end
            gcrd_pkg::OP_FOLD: begin
                if (r_u > gcrd_pkg::UDEG_90) begin
                    r_u    <= gcrd_pkg::UDEG_180 - r_u;
                    r_flip <= 1'b1;
                end else if (r_u < -gcrd_pkg::UDEG_90) begin
                    r_u    <= -gcrd_pkg::UDEG_180 - r_u;
                    r_flip <= 1'b1;
                end
            end
            // magnitude divided by 180e6: reciprocal estimate may be low, two correction steps raise it
            gcrd_pkg::OP_DIVINIT: begin
                r_zneg <= r_prod[PW-1];
                r_mag  <= mag;
            end
            gcrd_pkg::OP_DIV: begin
                if (i_cmd.step == DS_QEST) begin
                    r_dv <= r_prod[62:32];
                end else if (i_cmd.step == DS_REM) begin
                    r_rem <= 30'(r_mag - r_prod[58:0]);
                end else if (i_cmd.step > DS_REM) begin
                    if (r_rem >= {2'b0, gcrd_pkg::DIV_D}) begin
                        r_rem <= r_rem - {2'b0, gcrd_pkg::DIV_D};
                        r_dv  <= r_dv + 31'd1;
                    end
                end
            end
            gcrd_pkg::OP_ZSIGN: begin
                r_x <= gcrd_pkg::GAIN_INV;
                r_y <= '0;
                r_z <= r_zneg ? -CW'({1'b0, r_dv}) : CW'({1'b0, r_dv});
            end
            gcrd_pkg::OP_ROT: begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
            end
            gcrd_pkg::OP_STORE: begin
                r_s[i_cmd.slot] <= MW'(r_y);
                r_c[i_cmd.slot] <= r_flip ? MW'(negx) : MW'(r_x);
            end
            gcrd_pkg::OP_MCC: r_t1 <= t3;
            gcrd_pkg::OP_T2:  r_t2 <= t3;
            // clamp the acos argument to [-1, 1]
            gcrd_pkg::OP_ARG: begin
                r_aneg <= arg < 0;
                if (arg > (CW+1)'(1 << 30))
                    r_ax <= 31'(1 << 30);
                else if (arg < -(CW+1)'(1 << 30))
                    r_ax <= 31'(1 << 30);
                else if (arg < 0)
                    r_ax <= 31'(-arg);
                else
                    r_ax <= 31'(arg);
            end
            // floor square root of 2^60 - x^2, two radicand bits a cycle
            gcrd_pkg::OP_SQINIT: begin
                r_n   <= 61'(62'(1) << 60) - r_prod[60:0];
                r_r   <= '0;
                r_bit <= 61'(62'(1) << 60);
            end
            gcrd_pkg::OP_SQ: begin
                if ({1'b0, r_n} >= trial) begin
                    r_n <= 61'({1'b0, r_n} - trial);
                    r_r <= (r_r >> 1) + {1'b0, r_bit};
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            gcrd_pkg::OP_VECINIT: begin
                r_x <= CW'({1'b0, r_ax});
                r_y <= CW'(r_r);
                r_z <= '0;
            end
            gcrd_pkg::OP_VEC: begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end
            end
            gcrd_pkg::OP_THETA: begin
                if (th < 0)
                    r_theta <= '0;
                else if (th > CW'(gcrd_pkg::PI_Q30))
                    r_theta <= gcrd_pkg::PI_Q30;
                else
                    r_theta <= MW'(th);
            end
            default: begin
            end
        endcase
    end

    // Route state, config and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= gcrd_pkg::RADIUS_RST;
            r_prev_lat  <= '0;
            r_prev_lon  <= '0;
            r_have_prev <= 1'b0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) r_radius <= i_cfg_data;
            if (r_ovalid && i_ready && !(i_cmd.op == gcrd_pkg::OP_FINISH && r_last))
                r_ovalid <= 1'b0;
            unique case (i_cmd.op)
                gcrd_pkg::OP_ACC: begin
                    if (sum >= MAXV) begin
                        r_total <= MAXV[TOTAL_WIDTH-1:0];
                        r_ovf   <= 1'b1;
                    end else begin
                        r_total <= sum[TOTAL_WIDTH-1:0];
                    end
                end
                gcrd_pkg::OP_FINISH: begin
                    r_prev_lat  <= r_lat;
                    r_prev_lon  <= r_lon;
                    r_have_prev <= !r_last;
                    if (r_last) begin
                        r_ovalid <= 1'b1;
                        r_otot   <= r_total;
                        r_osat   <= r_ovf;
                        r_total  <= '0;
                        r_ovf    <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.have_prev = r_have_prev;
    assign o_stat.last      = r_last;
    assign o_stat.reduce_ok = (r_u <= gcrd_pkg::UDEG_180) && (r_u > -gcrd_pkg::UDEG_180);
    assign o_stat.out_block = r_ovalid && !i_ready;

    assign o_valid     = r_ovalid;
    assign o_total     = r_otot;
    assign o_saturated = r_osat;

endmodule

// ===== sv/great_circle_route_distance_top.sv =====
// Great-circle route distance: each waypoint word (latitude and longitude in
// microdegrees, plus a last-point flag) adds the spherical law-of-cosines leg
// from the previous point to a running total in metres, scaled by the
// programmable sphere radius; the total saturates with a sticky flag and one
// result word is sent on each last point, after which a new route starts.
// A single shared CORDIC unit, a 33x33 multiplier, a reciprocal-multiply
// divide and a square-root unit do all the work in sequence, one point at a
// time; the first point of a route adds no leg. A last point also holds in
// its finishing state while the previous total is still unread. The CORDIC
// iteration count and the three sin/cos evaluations set how long a point
// takes. A finished total waits in an output register while the next point
// is taken; the radius may be written only while idle.
module great_circle_route_distance_top #(
    parameter int CORDIC_STEPS = 24,
    parameter int TOTAL_WIDTH  = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data,
    gcrd_pt_if.sink     i_pt,
    gcrd_res_if.source  o_res
);

    gcrd_pkg::t_cmd  cmd;
    gcrd_pkg::t_stat stat;

    gcrd_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .o_in_ready (i_pt.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gcrd_dp #(.TOTAL_WIDTH(TOTAL_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_lat       (i_pt.latitude_udeg),
        .i_lon       (i_pt.longitude_udeg),
        .i_last      (i_pt.last_point),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_total     (o_res.total_distance_m),
        .o_saturated (o_res.saturated)
    );

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int        STEPS      = 24;
    localparam longint    ANGLE_PI   = 64'sd3373259426;
    localparam longint    CORDIC_K   = 64'sd652032874;
    localparam longint    HALF_TURN  = 64'sd180000000;
    localparam longint    QTR_TURN   = 64'sd90000000;
    localparam longint    UNIT_Q30   = 64'sd1073741824;
    localparam longint unsigned TOTAL_MAX = 64'hFF_FFFF_FFFF;
    localparam int        DRAIN_CYCLES = 400;
    localparam longint    CYCLE_LIMIT  = 3000000;

    localparam longint ATAN_TAB [32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    typedef struct packed {
        logic [39:0] total;
        logic        sat;
    } t_route_total;

    typedef struct {
        int          lat;
        int          lon;
        bit          last;
        bit          known;
        longint      total;
    } t_waypoint_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [23:0] i_cfg_data;

    gcrd_pt_if pt ();
    gcrd_res_if #(.TOTAL_W(40)) res ();

    great_circle_route_distance_top #(
        .CORDIC_STEPS(STEPS),
        .TOTAL_WIDTH (40)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_pt      (pt),
        .o_res     (res)
    );

    // Route state as the block should hold it
    longint unsigned radius_m;
    longint          route_lat;
    longint          route_lon;
    bit              route_open;
    longint unsigned route_sum;
    bit              route_sat;

    t_route_total    pending_totals [$];
    int              errors;
    int              send_idle;
    int              recv_idle;
    longint          cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // sin/cos of a microdegree angle, folded into +-90 degrees first
    function automatic void cordic_sin_cos(input longint udeg, output longint s,
                                           output longint c);
        bit     flip;
        longint x, y, z, dx, dy;
        flip = 0;
        while (udeg > HALF_TURN) udeg -= 2 * HALF_TURN;
        while (udeg <= -HALF_TURN) udeg += 2 * HALF_TURN;
        if (udeg > QTR_TURN) begin
            udeg = HALF_TURN - udeg;
            flip = 1;
        end else if (udeg < -QTR_TURN) begin
            udeg = -HALF_TURN - udeg;
            flip = 1;
        end
        x = CORDIC_K;
        y = 0;
        z = udeg * ANGLE_PI / HALF_TURN;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i & 31];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i & 31];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // acos via vectoring of (|v|, sqrt(1 - v^2))
    function automatic longint central_angle(input longint v);
        longint ax, x, y, z, dx, dy;
        ax = v < 0 ? -v : v;
        x  = ax;
        z  = 0;
        y  = longint'(floor_sqrt((64'd1 << 60) - longint'(ax * ax)));
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i & 31];
            end else begin
                x -= dx; y += dy; z -= ATAN_TAB[i & 31];
            end
        end
        if (v < 0) z = ANGLE_PI - z;
        if (z < 0) z = 0;
        if (z > ANGLE_PI) z = ANGLE_PI;
        return z;
    endfunction

    function automatic longint unsigned leg_length(input longint lat1, input longint lon1,
                                                   input longint lat2, input longint lon2);
        longint s1, c1, s2, c2, sd, cd, arg;
        cordic_sin_cos(lat1, s1, c1);
        cordic_sin_cos(lat2, s2, c2);
        cordic_sin_cos(lon2 - lon1, sd, cd);
        arg = ((s1 * s2) >>> 30) + ((((c1 * c2) >>> 30) * cd) >>> 30);
        if (arg > UNIT_Q30) arg = UNIT_Q30;
        if (arg < -UNIT_Q30) arg = -UNIT_Q30;
        return (radius_m * longint'(central_angle(arg)) + (64'd1 << 29)) >> 30;
    endfunction

    // Advance the route for one waypoint; returns 1 when a total is due
    function automatic bit add_waypoint(input logic signed [27:0] lat,
                                        input logic signed [28:0] lon, input bit last,
                                        output t_route_total t);
        longint unsigned sum;
        if (route_open) begin
            sum = route_sum + leg_length(route_lat, route_lon, lat, lon);
            if (sum < route_sum || sum >= TOTAL_MAX) begin
                sum = TOTAL_MAX;
                route_sat = 1;
            end
            route_sum = sum;
        end
        route_lat  = longint'(lat);
        route_lon  = longint'(lon);
        route_open = 1;
        t.total = route_sum[39:0];
        t.sat   = route_sat;
        if (!last) return 0;
        route_sum  = 0;
        route_sat  = 0;
        route_open = 0;
        return 1;
    endfunction

    // Send one waypoint word and queue the total it produces
    task automatic send_waypoint(input logic signed [27:0] lat, input logic signed [28:0] lon,
                                 input bit last, input bit known, input longint total);
        t_route_total t;
        while ($urandom_range(99) < send_idle) begin
            pt.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt.valid          <= 1'b1;
        pt.latitude_udeg  <= lat;
        pt.longitude_udeg <= lon;
        pt.last_point     <= last;
        @(posedge i_clk);
        while (!pt.ready) @(posedge i_clk);
        if (add_waypoint(lat, lon, last, t)) begin
            if (known) begin
                t.total = total[39:0];
                t.sat   = 1'b0;
            end
            pending_totals.push_back(t);
        end
    endtask

    task automatic wait_idle();
        pt.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [23:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        radius_m = 64'(v);
    endtask

    // Random routes, mostly on-globe points, some with any field value
    task automatic random_routes(input int items);
        int n, sent;
        logic signed [27:0] lat;
        logic signed [28:0] lon;
        sent = 0;
        while (sent < items) begin
            n = $urandom_range(1, 6);
            for (int j = 0; j < n; j++) begin
                if ($urandom_range(99) < 15) begin
                    lat = 28'($urandom);
                    lon = 29'($urandom);
                end else begin
                    lat = 28'($urandom_range(180000000) - 90000000);
                    lon = 29'($urandom_range(360000000) - 180000000);
                end
                send_waypoint(lat, lon, j == n - 1, 1'b0, 64'sd0);
                sent++;
            end
        end
    endtask

    // Result word checker and receiver backpressure
    always @(posedge i_clk) begin
        t_route_total want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_totals.size() == 0) begin
                report("unexpected total", longint'(res.total_distance_m), -64'sd1);
            end else begin
                want = pending_totals.pop_front();
                if (res.total_distance_m !== want.total)
                    report("total_distance_m", longint'(res.total_distance_m),
                           longint'(want.total));
                if (res.saturated !== want.sat)
                    report("saturated", longint'(res.saturated), longint'(want.sat));
            end
        end
        res.ready <= ($urandom_range(99) >= recv_idle);
    end

    t_waypoint_row directed [22] = '{
        '{90000000, 180000000, 1, 1, 0},
        '{-90000000, -180000000, 1, 1, 0},
        '{134217727, 268435455, 1, 1, 0},
        '{-134217728, -268435456, 1, 1, 0},
        '{0, 0, 0, 0, 0},
        '{0, 0, 1, 0, 0},
        '{90000000, 0, 0, 0, 0},
        '{-90000000, 0, 1, 0, 0},
        '{0, -180000000, 0, 0, 0},
        '{0, 180000000, 1, 0, 0},
        '{0, 170000000, 0, 0, 0},
        '{0, -170000000, 0, 0, 0},
        '{45000000, 100000000, 1, 0, 0},
        '{100000000, 0, 0, 0, 0},
        '{-100000000, 50000000, 1, 0, 0},
        '{0, 0, 0, 0, 0},
        '{0, 180000000, 1, 0, 0},
        '{134217727, 268435455, 0, 0, 0},
        '{-134217728, -268435456, 1, 0, 0},
        '{51500000, -120000, 0, 0, 0},
        '{40700000, -74000000, 0, 0, 0},
        '{35700000, 139700000, 1, 0, 0}
    };

    initial begin
        errors     = 0;
        send_idle  = 21;
        recv_idle  = 66;
        radius_m   = 64'(gcrd_pkg::RADIUS_RST);
        route_lat  = 0;
        route_lon  = 0;
        route_open = 0;
        route_sum  = 0;
        route_sat  = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        pt.valid   = 1'b0;
        pt.latitude_udeg  = '0;
        pt.longitude_udeg = '0;
        pt.last_point     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed waypoints at the reset radius
        foreach (directed[r])
            send_waypoint(28'(directed[r].lat), 29'(directed[r].lon), directed[r].last,
                          directed[r].known, directed[r].total);
        wait_idle();

        write_radius(24'hFFFFFF);
        random_routes(90);
        // Sender holds off until every total is back
        wait_idle();
        random_routes(90);
        wait_idle();

        send_idle = 66;
        recv_idle = 21;
        write_radius(24'd1);
        random_routes(150);
        wait_idle();

        send_idle = 0;
        recv_idle = 0;
        write_radius(24'd6371000);
        random_routes(150);
        wait_idle();

        write_radius(24'd0);
        random_routes(40);
        wait_idle();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/gcrd_pkg.sv
sv/gcrd_if.sv
sv/gcrd_ctrl.sv
sv/gcrd_dp.sv
sv/great_circle_route_distance_top.sv
tb/tb.sv
